### hw/rtl/eotc_pkg.sv
package eotc_pkg;

    // Field widths of the pixel and result items.
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 21;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // A structure mask byte marks a structural pixel at this level.
    localparam logic [PIX_W-1:0] STRUCT_LEVEL = 8'hFF;

    // Frame size after reset, in both directions.
    localparam logic [CFG_W-1:0] RESET_DIM = 11'd1024;

    // Defaults for the top level parameters.
    localparam int DEF_MATCH_RADIUS = 2;
    localparam int DEF_MAX_WIDTH    = 1024;
    localparam int DEF_MAX_HEIGHT   = 1024;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_idx;

    // One result item.
    typedef struct packed {
        logic [CNT_W-1:0] structure_count;
        logic [CNT_W-1:0] structure_matched;
        logic [CNT_W-1:0] event_count;
        logic [CNT_W-1:0] event_unmatched;
        logic [CNT_W-1:0] event_matched;
    } t_res;

endpackage

### hw/rtl/eotc_pix_if.sv
// Pixel pair channel: one structure byte and one event byte per item.
interface eotc_pix_if;
    logic                       valid;
    logic                       ready;
    logic [eotc_pkg::PIX_W-1:0] structure_pixel;
    logic [eotc_pkg::PIX_W-1:0] event_pixel;

    modport source (output valid, structure_pixel, event_pixel, input ready);
    modport sink   (input valid, structure_pixel, event_pixel, output ready);
endinterface

### hw/rtl/eotc_res_if.sv
// Result channel: the five frame counts per item.
interface eotc_res_if;
    logic                       valid;
    logic                       ready;
    logic [eotc_pkg::CNT_W-1:0] structure_count;
    logic [eotc_pkg::CNT_W-1:0] structure_matched;
    logic [eotc_pkg::CNT_W-1:0] event_count;
    logic [eotc_pkg::CNT_W-1:0] event_unmatched;
    logic [eotc_pkg::CNT_W-1:0] event_matched;

    modport source (output valid, structure_count, structure_matched, event_count,
                    event_unmatched, event_matched, input ready);
    modport sink   (input valid, structure_count, structure_matched, event_count,
                    event_unmatched, event_matched, output ready);
endinterface

### hw/rtl/edge_overlap_tolerance_counter.sv
// Edge overlap counter. Pixel pairs of a structure mask and an event mask enter in raster
// order, one item per clock with no gaps required, and the block counts per frame the
// structural pixels, the structural pixels with an event inside the (2R+1)x(2R+1) window
// (clipped to the frame), the event pixels, and the event pixels with no structural pixel in
// that window. The previous 2R rows of both masks live in one RAM with one word per column;
// each accepted pixel reads its column word and stage 1 writes it back shifted by one row,
// and that single read-modify-write per pixel sets the rate at one item per clock.
// Window centers run R rows and R columns behind the input; on the last column of a row and
// on the last row of the frame the pending edge centers, up to (R+1)x(R+1) of them, are
// judged in the same clock. Stage 4 pushes the result item after the frame's last pixel
// reaches it. Two result items can wait at the output before the input stalls. A write to
// frame_width or frame_height restarts the frame and drops items still in flight; write them
// only while the block is idle. A size of 0 acts as 1, a size above the maximum saturates.
module edge_overlap_tolerance_counter #(
    parameter int MATCH_RADIUS = eotc_pkg::DEF_MATCH_RADIUS,
    parameter int MAX_WIDTH    = eotc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = eotc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [eotc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [eotc_pkg::CFG_W-1:0]     i_cfg_data,
    eotc_pix_if.sink                       i_pix,
    eotc_res_if.source                     o_res
);

    localparam int R      = MATCH_RADIUS;
    localparam int NK     = 2 * R + 1;
    localparam int WORD_W = 4 * R;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int SW     = $clog2(NK);
    localparam int NC     = (R + 1) * (R + 1);
    localparam int PCW    = $clog2(NC + 1);
    localparam int CNT_W  = eotc_pkg::CNT_W;

    // Vertical window ORs of one column, one bit per judged row offset.
    typedef struct packed {
        logic [R:0] vs;
        logic [R:0] ve;
    } t_vrec;

    // Mask bits of one column for the rows that can hold a window center.
    typedef struct packed {
        logic [R:0] ps;
        logic [R:0] pe;
    } t_prec;

    typedef struct packed {
        t_vrec v;
        t_prec p;
    } t_colrec;

    // Effective last column index for a frame_width value.
    function automatic logic [CW-1:0] f_col_last(input logic [eotc_pkg::CFG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_WIDTH) begin
            res = CW'(MAX_WIDTH - 1);
        end else begin
            res = CW'(int'(v) - 1);
        end
        return res;
    endfunction

    // Effective last row index for a frame_height value.
    function automatic logic [RW-1:0] f_row_last(input logic [eotc_pkg::CFG_W-1:0] v);
        logic [RW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_HEIGHT) begin
            res = RW'(MAX_HEIGHT - 1);
        end else begin
            res = RW'(int'(v) - 1);
        end
        return res;
    endfunction

    // Frame geometry and raster position.
    logic [CW-1:0] r_col_last;
    logic [RW-1:0] r_row_last;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Pipeline control.
    logic w_adv;
    logic w_acc;
    logic w_cfg_hit;
    logic w_last_col;
    logic w_last_row;
    logic w_s_bit;
    logic w_e_bit;
    logic [SW-1:0] w_csat;
    logic [SW-1:0] w_rsat;

    // Stage 1: column word read back from the line store.
    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_col;
    logic              r_s1_s;
    logic              r_s1_e;
    logic [SW-1:0]     r_s1_csat;
    logic [SW-1:0]     r_s1_rsat;
    logic              r_s1_lcol;
    logic              r_s1_lrow;
    logic              r_fwd;
    logic [WORD_W-1:0] r_fwd_word;
    logic [WORD_W-1:0] w_ram_rdata;
    logic [WORD_W-1:0] w_word;
    logic [WORD_W-1:0] w_s1_wb;
    logic [NK-1:0]     w_colv_s;
    logic [NK-1:0]     w_colv_e;
    t_colrec           w_s1_rec;
    logic [R:0]        w_s1_jmask;
    logic [R:0]        w_s1_imask;
    logic [NK-1:0]     w_s1_cmask;

    // Stage 2: horizontal window over the column history.
    logic          r_s2_valid;
    t_colrec       r_s2_cur;
    logic [R:0]    r_s2_jmask;
    logic [R:0]    r_s2_imask;
    logic [NK-1:0] r_s2_cmask;
    logic          r_s2_last;
    t_vrec         r_vh [2*R];
    t_prec         r_ph [R];
    t_vrec         w_vm [NK];
    t_prec         w_pm [R+1];
    logic [NC-1:0] w_sm;
    logic [NC-1:0] w_eu;

    // Stage 3: judged center bits.
    logic          r_s3_valid;
    logic [NC-1:0] r_s3_sm;
    logic [NC-1:0] r_s3_eu;
    logic          r_s3_s;
    logic          r_s3_e;
    logic          r_s3_last;

    // Stage 4: per-pixel increments.
    logic           r_s4_valid;
    logic [PCW-1:0] r_s4_nsm;
    logic [PCW-1:0] r_s4_neu;
    logic           r_s4_s;
    logic           r_s4_e;
    logic           r_s4_last;

    // Frame counters.
    logic [CNT_W-1:0] r_cnt_s;
    logic [CNT_W-1:0] r_cnt_sm;
    logic [CNT_W-1:0] r_cnt_e;
    logic [CNT_W-1:0] r_cnt_eu;
    logic [CNT_W-1:0] n_cnt_s;
    logic [CNT_W-1:0] n_cnt_sm;
    logic [CNT_W-1:0] n_cnt_e;
    logic [CNT_W-1:0] n_cnt_eu;
    logic             w_push;
    eotc_pkg::t_res   w_res_in;

    // Two-entry result queue.
    eotc_pkg::t_res r_oq [2];
    logic           r_owr;
    logic           r_ord;
    logic [1:0]     r_ocnt;
    logic           w_pop;

    // The whole pipeline moves while the result queue has room.
    assign w_adv       = (r_ocnt != 2'd2);
    assign i_pix.ready = w_adv;
    assign w_acc       = i_pix.valid && w_adv;
    assign w_cfg_hit   = i_cfg_we && ((i_cfg_index == eotc_pkg::REG_FRAME_WIDTH) ||
                                      (i_cfg_index == eotc_pkg::REG_FRAME_HEIGHT));

    // Classify the incoming pixel and saturate its position to the window reach.
    assign w_s_bit    = (i_pix.structure_pixel == eotc_pkg::STRUCT_LEVEL);
    assign w_e_bit    = |i_pix.event_pixel;
    assign w_last_col = (r_col == r_col_last);
    assign w_last_row = (r_row == r_row_last);
    assign w_csat     = (int'(r_col) >= 2 * R) ? SW'(2 * R) : SW'(r_col);
    assign w_rsat     = (int'(r_row) >= 2 * R) ? SW'(2 * R) : SW'(r_row);

    // Configuration registers hold the effective last index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= f_col_last(eotc_pkg::RESET_DIM);
            r_row_last <= f_row_last(eotc_pkg::RESET_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                eotc_pkg::REG_FRAME_WIDTH: begin
                    r_col_last <= f_col_last(i_cfg_data);
                end
                eotc_pkg::REG_FRAME_HEIGHT: begin
                    r_row_last <= f_row_last(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // Raster position of the next pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            if (w_last_col) begin
                r_col <= '0;
                if (w_last_row) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Line store: one word per column with the previous 2R rows.
    eotc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && w_adv),
        .i_waddr (r_s1_col),
        .i_wdata (w_s1_wb),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_ram_rdata)
    );

    // Stage 1 control; a write-back to the column being read is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (w_cfg_hit) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc;
            r_fwd      <= w_acc && r_s1_valid && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_col   <= r_col;
            r_s1_s     <= w_s_bit;
            r_s1_e     <= w_e_bit;
            r_s1_csat  <= w_csat;
            r_s1_rsat  <= w_rsat;
            r_s1_lcol  <= w_last_col;
            r_s1_lrow  <= w_last_row;
            r_fwd_word <= w_s1_wb;
        end
    end

    // Stage 1: assemble the column, write it back one row down, OR it vertically.
    always_comb begin
        w_word      = r_fwd ? r_fwd_word : w_ram_rdata;
        w_colv_s[0] = r_s1_s;
        w_colv_e[0] = r_s1_e;
        for (int k = 1; k < NK; k++) begin
            w_colv_s[k] = w_word[2*(k-1)];
            w_colv_e[k] = w_word[2*(k-1)+1];
        end
        for (int k = 0; k < NK - 1; k++) begin
            w_s1_wb[2*k]   = w_colv_s[k];
            w_s1_wb[2*k+1] = w_colv_e[k];
        end
        for (int j = 0; j <= R; j++) begin
            w_s1_rec.v.vs[j] = 1'b0;
            w_s1_rec.v.ve[j] = 1'b0;
            for (int k = 0; k < NK; k++) begin
                if ((k <= j + R) && (SW'(k) <= r_s1_rsat)) begin
                    w_s1_rec.v.vs[j] = w_s1_rec.v.vs[j] | w_colv_s[k];
                    w_s1_rec.v.ve[j] = w_s1_rec.v.ve[j] | w_colv_e[k];
                end
            end
            w_s1_rec.p.ps[j] = w_colv_s[j];
            w_s1_rec.p.pe[j] = w_colv_e[j];
            // Centers judged now: one row back R, or every pending row on the last row.
            w_s1_jmask[j] = r_s1_lrow ? (SW'(j) <= r_s1_rsat)
                                      : ((j == R) && (r_s1_rsat >= SW'(R)));
            w_s1_imask[j] = r_s1_lcol ? (SW'(j) <= r_s1_csat)
                                      : ((j == R) && (r_s1_csat >= SW'(R)));
        end
        for (int m = 0; m < NK; m++) begin
            w_s1_cmask[m] = (SW'(m) <= r_s1_csat);
        end
    end

    // Stage 2 registers and column history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_cfg_hit) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_s2_cur   <= w_s1_rec;
            r_s2_jmask <= w_s1_jmask;
            r_s2_imask <= w_s1_imask;
            r_s2_cmask <= w_s1_cmask;
            r_s2_last  <= r_s1_lcol && r_s1_lrow;
        end
        if (w_adv && r_s2_valid) begin
            r_vh[0] <= r_s2_cur.v;
            for (int m = 1; m < 2 * R; m++) begin
                r_vh[m] <= r_vh[m-1];
            end
            r_ph[0] <= r_s2_cur.p;
            for (int m = 1; m < R; m++) begin
                r_ph[m] <= r_ph[m-1];
            end
        end
    end

    // Stage 2: horizontal window and verdict for each center judged this clock.
    always_comb begin
        logic hs;
        logic he;
        logic sel;
        w_vm[0] = r_s2_cur.v;
        for (int m = 1; m < NK; m++) begin
            w_vm[m] = r_vh[m-1];
        end
        w_pm[0] = r_s2_cur.p;
        for (int m = 1; m <= R; m++) begin
            w_pm[m] = r_ph[m-1];
        end
        for (int j = 0; j <= R; j++) begin
            for (int i = 0; i <= R; i++) begin
                hs = 1'b0;
                he = 1'b0;
                for (int m = 0; m < NK; m++) begin
                    if ((m <= i + R) && r_s2_cmask[m]) begin
                        hs = hs | w_vm[m].vs[j];
                        he = he | w_vm[m].ve[j];
                    end
                end
                sel = r_s2_jmask[j] & r_s2_imask[i];
                w_sm[j*(R+1)+i] = sel & w_pm[i].ps[j] & he;
                w_eu[j*(R+1)+i] = sel & w_pm[i].pe[j] & ~hs;
            end
        end
    end

    // Stage 3 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_cfg_hit) begin
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_s3_sm   <= w_sm;
            r_s3_eu   <= w_eu;
            r_s3_s    <= r_s2_cur.p.ps[0];
            r_s3_e    <= r_s2_cur.p.pe[0];
            r_s3_last <= r_s2_last;
        end
    end

    // Stage 4 registers: count the verdicts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_cfg_hit) begin
            r_s4_valid <= 1'b0;
        end else if (w_adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s3_valid) begin
            r_s4_nsm  <= PCW'($countones(r_s3_sm));
            r_s4_neu  <= PCW'($countones(r_s3_eu));
            r_s4_s    <= r_s3_s;
            r_s4_e    <= r_s3_e;
            r_s4_last <= r_s3_last;
        end
    end

    // Accumulate, and on the frame's last pixel hand the totals to the result queue.
    assign n_cnt_s  = r_cnt_s + CNT_W'(r_s4_s);
    assign n_cnt_sm = r_cnt_sm + CNT_W'(r_s4_nsm);
    assign n_cnt_e  = r_cnt_e + CNT_W'(r_s4_e);
    assign n_cnt_eu = r_cnt_eu + CNT_W'(r_s4_neu);
    assign w_push   = w_adv && r_s4_valid && r_s4_last;

    assign w_res_in.structure_count   = n_cnt_s;
    assign w_res_in.structure_matched = n_cnt_sm;
    assign w_res_in.event_count       = n_cnt_e;
    assign w_res_in.event_unmatched   = n_cnt_eu;
    assign w_res_in.event_matched     = n_cnt_e - n_cnt_eu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_s  <= '0;
            r_cnt_sm <= '0;
            r_cnt_e  <= '0;
            r_cnt_eu <= '0;
        end else if (w_cfg_hit || w_push) begin
            r_cnt_s  <= '0;
            r_cnt_sm <= '0;
            r_cnt_e  <= '0;
            r_cnt_eu <= '0;
        end else if (w_adv && r_s4_valid) begin
            r_cnt_s  <= n_cnt_s;
            r_cnt_sm <= n_cnt_sm;
            r_cnt_e  <= n_cnt_e;
            r_cnt_eu <= n_cnt_eu;
        end
    end

    // Result queue.
    assign w_pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_owr <= ~r_owr;
            end
            if (w_pop) begin
                r_ord <= ~r_ord;
            end
            if (w_push && !w_pop) begin
                r_ocnt <= r_ocnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_ocnt <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_oq[r_owr] <= w_res_in;
        end
    end

    assign o_res.valid             = (r_ocnt != 2'd0);
    assign o_res.structure_count   = r_oq[r_ord].structure_count;
    assign o_res.structure_matched = r_oq[r_ord].structure_matched;
    assign o_res.event_count       = r_oq[r_ord].event_count;
    assign o_res.event_unmatched   = r_oq[r_ord].event_unmatched;
    assign o_res.event_matched     = r_oq[r_ord].event_matched;

    // The raster position never leaves the configured frame.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("raster position outside the frame");

    // Taking the frame's last pixel wraps the position to the frame origin.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last_col && w_last_row) |=> ((r_col == '0) && (r_row == '0)))
        else $error("position did not wrap after the last pixel");

    // A finished frame is offered at the output in the next clock.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_res.valid)
        else $error("result item not offered after the frame ended");

    // Matched and unmatched counts never exceed the totals they are drawn from.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.structure_matched <= o_res.structure_count) &&
                         (o_res.event_unmatched <= o_res.event_count)))
        else $error("matched count exceeds total count");

endmodule

### hw/rtl/eotc_ram.sv
// Simple dual port RAM with one write port and one registered read port.
module eotc_ram #(
    parameter int WIDTH = 4 * eotc_pkg::DEF_MATCH_RADIUS,
    parameter int DEPTH = eotc_pkg::DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
